### design/decimal_significant_digit_scanner_unit_macros.svh
// Assertion macros used by the scanner back end (dsds_back).
`ifndef DECIMAL_SIGNIFICANT_DIGIT_SCANNER_UNIT_MACROS_SVH
`define DECIMAL_SIGNIFICANT_DIGIT_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication.
`define DSDS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define DSDS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### design/dsds_pkg.sv
package dsds_pkg;

   localparam int POS_W   = 18;
   localparam int POS_MIN = -131072;
   localparam int POS_MAX = 131071;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   localparam logic [2:0] TK_DIGIT = 3'd0;
   localparam logic [2:0] TK_POINT = 3'd1;
   localparam logic [2:0] TK_EXP   = 3'd2;
   localparam logic [2:0] TK_PLUS  = 3'd3;
   localparam logic [2:0] TK_MINUS = 3'd4;
   localparam logic [2:0] TK_END   = 3'd5;
   localparam logic [2:0] TK_OTHER = 3'd6;

   typedef struct packed {
      logic [2:0] cls;
      logic [3:0] val;
   } tok_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

endpackage

### design/dsds_front.sv
module dsds_front
   import dsds_pkg::*;
(
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   input  qstat_type  qstat,
   output logic       push,
   output tok_type    push_tok
);

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_POINT = 8'h2E;
   localparam logic [7:0] CH_LO_E  = 8'h65;
   localparam logic [7:0] CH_UP_E  = 8'h45;
   localparam logic [7:0] CH_NUL   = 8'h00;

   assign req_stall = qstat.full;
   assign push      = req_valid && !qstat.full;

   always_comb begin
      push_tok.val = 4'd0;
      if (req_char_code inside {[CH_0:CH_9]}) begin
         push_tok.cls = TK_DIGIT;
         push_tok.val = 4'(req_char_code - CH_0);
      end else if (req_char_code == CH_POINT) begin
         push_tok.cls = TK_POINT;
      end else if (req_char_code inside {CH_LO_E, CH_UP_E}) begin
         push_tok.cls = TK_EXP;
      end else if (req_char_code == CH_PLUS) begin
         push_tok.cls = TK_PLUS;
      end else if (req_char_code == CH_MINUS) begin
         push_tok.cls = TK_MINUS;
      end else if (req_char_code == CH_NUL) begin
         push_tok.cls = TK_END;
      end else begin
         push_tok.cls = TK_OTHER;
      end
   end

endmodule

### design/dsds_queue.sv
module dsds_queue
   import dsds_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  tok_type   push_tok,
   input  logic      pop,
   output tok_type   pop_tok,
   output qstat_type qstat
);

   tok_type             slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign qstat.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_tok     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_tok;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### design/dsds_back.sv
`include "decimal_significant_digit_scanner_unit_macros.svh"

module dsds_back
   import dsds_pkg::*;
#(
   parameter int MAX_DIGITS = 65535,
   parameter int EXP_MAX    = 65535
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  qstat_type               qstat,
   input  tok_type                 pop_tok,
   output logic                    pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ok,
   output logic                    rsp_is_zero,
   output logic signed [POS_W-1:0] rsp_top_position,
   output logic signed [POS_W-1:0] rsp_bottom_position
);

   localparam int FW  = $clog2(MAX_DIGITS + 1);
   localparam int CW  = FW + 1;
   localparam int EW  = $clog2(EXP_MAX + 1);
   localparam int EXW = EW + 4;
   localparam int SW  = ((CW > EW + 1) ? CW : EW + 1) + 1;
   localparam int XW  = (SW > POS_W) ? SW : POS_W;

   localparam logic signed [XW-1:0]    X_MIN = XW'(POS_MIN);
   localparam logic signed [XW-1:0]    X_MAX = XW'(POS_MAX);
   localparam logic signed [POS_W-1:0] P_MIN = POS_W'(POS_MIN);
   localparam logic signed [POS_W-1:0] P_MAX = POS_W'(POS_MAX);

   localparam logic [3:0] PH_START       = 4'd0;
   localparam logic [3:0] PH_LEAD        = 4'd1;
   localparam logic [3:0] PH_INT         = 4'd2;
   localparam logic [3:0] PH_FRAC        = 4'd3;
   localparam logic [3:0] PH_EXP_START   = 4'd4;
   localparam logic [3:0] PH_EXP_DIGITS  = 4'd5;
   localparam logic [3:0] PH_DONE_REJECT = 4'd6;
   localparam logic [3:0] PH_DONE_ZERO   = 4'd7;
   localparam logic [3:0] PH_DONE_ACCEPT = 4'd8;

   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_ZERO   = 2'd2;
   localparam logic [1:0] KIND_VALUE  = 2'd3;

   logic [3:0]           phase_ff, phase_in;
   logic                 lead0_ff, lead0_in;
   logic signed [CW-1:0] top_ff, top_in;
   logic signed [CW-1:0] bot_ff, bot_in;
   logic [FW-1:0]        frac_ff, frac_in;
   logic                 top_fixed_ff, top_fixed_in;
   logic [EW-1:0]        exp_ff, exp_in;
   logic                 exp_neg_ff, exp_neg_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_ok_ff, rsp_ok_in;
   logic                    rsp_zero_ff, rsp_zero_in;
   logic signed [POS_W-1:0] rsp_top_ff, rsp_top_in;
   logic signed [POS_W-1:0] rsp_bot_ff, rsp_bot_in;

   logic                 slot_free;
   logic [1:0]           kind;
   logic [3:0]           eff_phase;
   logic signed [CW-1:0] frac_pos;
   logic [EXW-1:0]       exp_mul;
   logic signed [EW:0]   exp_s;
   logic signed [SW-1:0] sum_top, sum_bot;
   logic signed [XW-1:0] ext_top, ext_bot;
   logic signed [POS_W-1:0] clamp_top, clamp_bot;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign pop       = !qstat.empty && (pop_tok.cls != TK_END || slot_free);
   assign eff_phase = (phase_ff == PH_START) ? PH_LEAD : phase_ff;
   assign frac_pos  = $signed(~{1'b0, frac_ff});
   assign exp_mul   = (EXW'(exp_ff) << 3) + (EXW'(exp_ff) << 1) + EXW'(pop_tok.val);

   always_comb begin
      phase_in     = eff_phase;
      lead0_in     = lead0_ff;
      top_in       = top_ff;
      bot_in       = bot_ff;
      frac_in      = frac_ff;
      top_fixed_in = top_fixed_ff;
      exp_in       = exp_ff;
      exp_neg_in   = exp_neg_ff;
      kind         = KIND_NONE;
      if (phase_ff == PH_START && pop_tok.cls inside {TK_PLUS, TK_MINUS}) begin
         phase_in = PH_LEAD;
      end else begin
         case (eff_phase)
            PH_LEAD: begin
               if (pop_tok.cls == TK_DIGIT && pop_tok.val == 4'd0) begin
                  lead0_in = 1'b1;
               end else if (pop_tok.cls == TK_END) begin
                  kind = lead0_ff ? KIND_ZERO : KIND_REJECT;
               end else if (pop_tok.cls == TK_DIGIT) begin
                  phase_in = PH_INT;
                  top_in   = '0;
                  bot_in   = '0;
               end else if (pop_tok.cls == TK_POINT) begin
                  phase_in     = PH_FRAC;
                  bot_in       = '0;
                  top_fixed_in = 1'b0;
               end else begin
                  phase_in = PH_DONE_REJECT;
               end
            end
            PH_INT: begin
               case (pop_tok.cls)
                  TK_DIGIT: begin
                     if (top_ff < CW'(MAX_DIGITS)) begin
                        top_in = top_ff + CW'(1);
                     end
                     if (pop_tok.val != 4'd0) begin
                        bot_in = '0;
                     end else if (bot_ff < CW'(MAX_DIGITS)) begin
                        bot_in = bot_ff + CW'(1);
                     end
                  end
                  TK_POINT: begin
                     phase_in     = PH_FRAC;
                     bot_in       = '0;
                     top_fixed_in = 1'b1;
                  end
                  TK_END:  kind     = KIND_VALUE;
                  TK_EXP:  phase_in = PH_EXP_START;
                  default: phase_in = PH_DONE_REJECT;
               endcase
            end
            PH_FRAC: begin
               if (pop_tok.cls == TK_DIGIT) begin
                  if (pop_tok.val != 4'd0) begin
                     bot_in = frac_pos;
                     if (!top_fixed_ff) begin
                        top_in       = frac_pos;
                        top_fixed_in = 1'b1;
                     end
                  end
                  if (frac_ff < FW'(MAX_DIGITS)) begin
                     frac_in = frac_ff + 1'b1;
                  end
               end else if (!top_fixed_ff) begin
                  if (pop_tok.cls == TK_END) begin
                     kind = KIND_ZERO;
                  end else begin
                     phase_in = PH_DONE_ZERO;
                  end
               end else if (pop_tok.cls == TK_END) begin
                  kind = KIND_VALUE;
               end else if (pop_tok.cls == TK_EXP) begin
                  phase_in = PH_EXP_START;
               end else begin
                  phase_in = PH_DONE_REJECT;
               end
            end
            PH_EXP_START: begin
               case (pop_tok.cls)
                  TK_MINUS: begin
                     exp_neg_in = 1'b1;
                     phase_in   = PH_EXP_DIGITS;
                  end
                  TK_PLUS: phase_in = PH_EXP_DIGITS;
                  TK_DIGIT: begin
                     exp_in   = EW'(pop_tok.val);
                     phase_in = PH_EXP_DIGITS;
                  end
                  TK_END:  kind     = KIND_REJECT;
                  default: phase_in = PH_DONE_REJECT;
               endcase
            end
            PH_EXP_DIGITS: begin
               if (pop_tok.cls == TK_DIGIT) begin
                  if (exp_mul > EXW'(EXP_MAX)) begin
                     exp_in = EW'(EXP_MAX);
                  end else begin
                     exp_in = exp_mul[EW-1:0];
                  end
               end else if (pop_tok.cls == TK_END) begin
                  kind = KIND_VALUE;
               end else begin
                  phase_in = PH_DONE_ACCEPT;
               end
            end
            PH_DONE_REJECT: if (pop_tok.cls == TK_END) kind = KIND_REJECT;
            PH_DONE_ZERO:   if (pop_tok.cls == TK_END) kind = KIND_ZERO;
            PH_DONE_ACCEPT: if (pop_tok.cls == TK_END) kind = KIND_VALUE;
            default: begin
               phase_in = PH_DONE_REJECT;
               if (pop_tok.cls == TK_END) kind = KIND_REJECT;
            end
         endcase
      end
      if (kind != KIND_NONE) begin
         phase_in     = PH_START;
         lead0_in     = 1'b0;
         top_in       = -CW'(1);
         bot_in       = '0;
         frac_in      = '0;
         top_fixed_in = 1'b0;
         exp_in       = '0;
         exp_neg_in   = 1'b0;
      end
   end

   always_comb begin
      exp_s   = exp_neg_ff ? -$signed({1'b0, exp_ff}) : $signed({1'b0, exp_ff});
      sum_top = SW'(top_ff) + SW'(exp_s);
      sum_bot = SW'(bot_ff) + SW'(exp_s);
      ext_top = XW'(sum_top);
      ext_bot = XW'(sum_bot);
      if (ext_top < X_MIN) begin
         clamp_top = P_MIN;
      end else if (ext_top > X_MAX) begin
         clamp_top = P_MAX;
      end else begin
         clamp_top = ext_top[POS_W-1:0];
      end
      if (ext_bot < X_MIN) begin
         clamp_bot = P_MIN;
      end else if (ext_bot > X_MAX) begin
         clamp_bot = P_MAX;
      end else begin
         clamp_bot = ext_bot[POS_W-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_ok_in    = rsp_ok_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_top_in   = rsp_top_ff;
      rsp_bot_in   = rsp_bot_ff;
      if (pop && kind != KIND_NONE) begin
         rsp_valid_in = 1'b1;
         case (kind)
            KIND_ZERO: begin
               rsp_ok_in   = 1'b1;
               rsp_zero_in = 1'b1;
               rsp_top_in  = P_MIN;
               rsp_bot_in  = P_MIN;
            end
            KIND_VALUE: begin
               rsp_ok_in   = 1'b1;
               rsp_zero_in = 1'b0;
               rsp_top_in  = clamp_top;
               rsp_bot_in  = clamp_bot;
            end
            default: begin
               rsp_ok_in   = 1'b0;
               rsp_zero_in = 1'b0;
               rsp_top_in  = '0;
               rsp_bot_in  = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         lead0_ff     <= 1'b0;
         top_ff       <= -CW'(1);
         bot_ff       <= '0;
         frac_ff      <= '0;
         top_fixed_ff <= 1'b0;
         exp_ff       <= '0;
         exp_neg_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff     <= phase_in;
            lead0_ff     <= lead0_in;
            top_ff       <= top_in;
            bot_ff       <= bot_in;
            frac_ff      <= frac_in;
            top_fixed_ff <= top_fixed_in;
            exp_ff       <= exp_in;
            exp_neg_ff   <= exp_neg_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ok_ff   <= rsp_ok_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_top_ff  <= rsp_top_in;
      rsp_bot_ff  <= rsp_bot_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_ok              = rsp_ok_ff;
   assign rsp_is_zero         = rsp_zero_ff;
   assign rsp_top_position    = rsp_top_ff;
   assign rsp_bottom_position = rsp_bot_ff;

   `DSDS_ASSERT_NOW(a_reject_clear, clock, reset, rsp_valid_ff && !rsp_ok_ff,
      !rsp_zero_ff && rsp_top_ff == '0 && rsp_bot_ff == '0, "reject result not cleared")
   `DSDS_ASSERT_NOW(a_zero_min, clock, reset, rsp_valid_ff && rsp_zero_ff,
      rsp_ok_ff && rsp_top_ff == P_MIN && rsp_bot_ff == P_MIN, "zero result malformed")
   `DSDS_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, !qstat.empty,
      "pop from empty queue")
   `DSDS_ASSERT_NEXT(a_end_resets, clock, reset, pop && pop_tok.cls == TK_END,
      phase_ff == PH_START && !lead0_ff && exp_ff == '0, "scan state not reset after end")

endmodule

### design/decimal_significant_digit_scanner_unit.sv
// Decimal significant-digit scanner: takes one ASCII character per cycle on the req_
// channel while req_stall is low; a zero byte ends the text and produces one result on
// the rsp_ channel after passing the token queue and the registered result stage. A
// classifier feeds a four-entry token queue; the scan engine behind it retires one
// token per cycle and halts only on a terminator while the previous result is still
// waiting, so the sustained rate is one character per cycle and req_stall rises only
// when the queue fills. MAX_DIGITS bounds the digit counters and EXP_MAX the exponent;
// both set the width of the internal counters and the final shift-and-clamp adder.
module decimal_significant_digit_scanner_unit
   import dsds_pkg::*;
#(
   parameter int MAX_DIGITS = 65535,
   parameter int EXP_MAX    = 65535
)
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [7:0]              req_char_code,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_ok,
   output logic                    rsp_is_zero,
   output logic signed [POS_W-1:0] rsp_top_position,
   output logic signed [POS_W-1:0] rsp_bottom_position
);

   qstat_type qstat;
   logic      push;
   logic      pop;
   tok_type   push_tok;
   tok_type   pop_tok;

   dsds_front u_front (
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_char_code (req_char_code),
      .qstat         (qstat),
      .push          (push),
      .push_tok      (push_tok)
   );

   dsds_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_tok (push_tok),
      .pop      (pop),
      .pop_tok  (pop_tok),
      .qstat    (qstat)
   );

   dsds_back #(
      .MAX_DIGITS (MAX_DIGITS),
      .EXP_MAX    (EXP_MAX)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .qstat               (qstat),
      .pop_tok             (pop_tok),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_ok              (rsp_ok),
      .rsp_is_zero         (rsp_is_zero),
      .rsp_top_position    (rsp_top_position),
      .rsp_bottom_position (rsp_bottom_position)
   );

endmodule
